>>> rtl/ecif_pkg.sv
package ecif_pkg;

  localparam int DEF_EVENT_DEPTH = 8;
  localparam int DEF_SPACE_BYTES = 256;

  localparam logic [7:0] CMD_READ      = 8'h80;
  localparam logic [7:0] CMD_WRITE     = 8'h81;
  localparam logic [7:0] CMD_BURST_ON  = 8'h82;
  localparam logic [7:0] CMD_BURST_OFF = 8'h83;
  localparam logic [7:0] CMD_QUERY     = 8'h84;
  localparam logic [7:0] BURST_REPLY   = 8'h90;

  localparam logic [7:0] ST_OUT_FULL = 8'h01;
  localparam logic [7:0] ST_IN_FULL  = 8'h02;
  localparam logic [7:0] ST_BURST    = 8'h10;
  localparam logic [7:0] ST_EVENT    = 8'h20;

  typedef enum logic [2:0] {
    MODE_CMD    = 3'd0,
    MODE_DATA_W = 3'd1,
    MODE_DATA_R = 3'd2,
    MODE_STATUS = 3'd3,
    MODE_EVENT  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_RD_OFF = 2'd1,
    PH_WR_OFF = 2'd2,
    PH_WR_VAL = 2'd3
  } phase_t;

  // write request into one of the memories
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } wr_req_t;

endpackage

>>> rtl/ecif_space_mem.sv
module ecif_space_mem #(
  parameter int SPACE_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [7:0]        rd_addr,
  input  ecif_pkg::wr_req_t wr,
  output logic [7:0]        rd_data
);
  import ecif_pkg::*;

  localparam int SW = $clog2(SPACE_BYTES);

  logic [7:0]             mem [SPACE_BYTES];
  logic [SPACE_BYTES-1:0] vld;
  logic [7:0]             rdata;
  logic                   rvld;
  logic                   rd_in_range;

  assign rd_in_range = int'(rd_addr) < SPACE_BYTES;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[SW-1:0]] <= wr.data;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr[SW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvld <= 1'b0;
    end else if (rd_en) begin
      if (!rd_in_range) begin
        rvld <= 1'b0;
      end else if (wr.en && wr.addr == rd_addr) begin
        rvld <= 1'b1;
      end else begin
        rvld <= vld[rd_addr[SW-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en && rd_in_range) begin
      if (wr.en && wr.addr == rd_addr) begin
        rdata <= wr.data;
      end else begin
        rdata <= mem[rd_addr[SW-1:0]];
      end
    end
  end

  assign rd_data = rvld ? rdata : 8'h00;

endmodule

>>> rtl/ecif_event_mem.sv
module ecif_event_mem #(
  parameter int EVENT_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [7:0]        rd_addr,
  input  ecif_pkg::wr_req_t wr,
  output logic [7:0]        rd_data
);
  import ecif_pkg::*;

  localparam int EW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;

  logic [7:0] mem [EVENT_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[EW-1:0]] <= wr.data;
    end
  end

  // pushing into an empty queue while the head is read: pass the new byte on
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && wr.addr[EW-1:0] == rd_addr[EW-1:0]) begin
        rd_data <= wr.data;
      end else begin
        rd_data <= mem[rd_addr[EW-1:0]];
      end
    end
  end

endmodule

>>> rtl/ecif_ctrl.sv
module ecif_ctrl #(
  parameter int EVENT_DEPTH = 8,
  parameter int SPACE_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [2:0]        b_mode,
  input  logic [7:0]        b_byte,
  input  logic [7:0]        sp_rdata,
  input  logic [7:0]        ev_rdata,
  output ecif_pkg::wr_req_t sp_wr,
  output ecif_pkg::wr_req_t ev_wr,
  output logic [7:0]        ev_raddr,
  output logic [7:0]        res_byte,
  output logic              res_err
);
  import ecif_pkg::*;

  localparam int EW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int CW = $clog2(EVENT_DEPTH + 1);

  phase_t        phase, phase_next;
  logic [7:0]    offset_latch, offset_latch_next;
  logic [7:0]    out_buffer, out_buffer_next;
  logic          out_full, out_full_next;
  logic          burst_on, burst_on_next;
  logic [EW-1:0] head, tail;
  logic [CW-1:0] count;
  logic          pop, push;
  logic          q_empty, q_full;
  logic          off_in_range;

  function automatic logic [EW-1:0] ptr_inc(input logic [EW-1:0] p);
    return (p == EW'(EVENT_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign q_empty      = count == '0;
  assign q_full       = count == CW'(EVENT_DEPTH);
  assign off_in_range = int'(offset_latch) < SPACE_BYTES;

  always_comb begin
    phase_next = phase;
    unique case (b_mode)
      MODE_CMD: begin
        unique case (b_byte)
          CMD_READ:  phase_next = PH_RD_OFF;
          CMD_WRITE: phase_next = PH_WR_OFF;
          default:   phase_next = PH_IDLE;
        endcase
      end
      MODE_DATA_W: begin
        unique case (phase)
          PH_WR_OFF: phase_next = PH_WR_VAL;
          default:   phase_next = PH_IDLE;
        endcase
      end
      default: phase_next = phase;
    endcase
  end

  always_comb begin
    res_byte          = 8'h00;
    res_err           = 1'b0;
    offset_latch_next = offset_latch;
    out_buffer_next   = out_buffer;
    out_full_next     = out_full;
    burst_on_next     = burst_on;
    pop               = 1'b0;
    push              = 1'b0;
    sp_wr             = '{en: 1'b0, addr: offset_latch, data: b_byte};
    unique case (b_mode)
      MODE_CMD: begin
        unique case (b_byte)
          CMD_READ, CMD_WRITE: ;
          CMD_BURST_ON: begin
            burst_on_next   = 1'b1;
            out_buffer_next = BURST_REPLY;
            out_full_next   = 1'b1;
          end
          CMD_BURST_OFF: burst_on_next = 1'b0;
          CMD_QUERY: begin
            pop             = !q_empty;
            out_buffer_next = q_empty ? 8'h00 : ev_rdata;
            out_full_next   = 1'b1;
          end
          default: res_err = 1'b1;
        endcase
      end
      MODE_DATA_W: begin
        unique case (phase)
          PH_RD_OFF: begin
            out_buffer_next = sp_rdata;
            out_full_next   = 1'b1;
          end
          PH_WR_OFF: offset_latch_next = b_byte;
          PH_WR_VAL: sp_wr.en = off_in_range;
          PH_IDLE:   res_err = 1'b1;
        endcase
      end
      MODE_DATA_R: begin
        if (out_full) begin
          res_byte      = out_buffer;
          out_full_next = 1'b0;
        end else begin
          res_err = 1'b1;
        end
      end
      MODE_STATUS: begin
        res_byte = (out_full ? ST_OUT_FULL : 8'h00) | (burst_on ? ST_BURST : 8'h00) |
                   (q_empty ? 8'h00 : ST_EVENT);
      end
      MODE_EVENT: begin
        res_err = q_full;
        push    = !q_full;
      end
      default: ;
    endcase
    sp_wr.en = sp_wr.en && fire;
  end

  assign ev_wr    = '{en: push && fire, addr: 8'(tail), data: b_byte};
  // the next request reads the head as this one leaves it
  assign ev_raddr = 8'((pop && fire) ? ptr_inc(head) : head);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      offset_latch <= 8'h00;
      out_buffer   <= 8'h00;
      out_full     <= 1'b0;
      burst_on     <= 1'b0;
      head         <= '0;
      tail         <= '0;
      count        <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      offset_latch <= offset_latch_next;
      out_buffer   <= out_buffer_next;
      out_full     <= out_full_next;
      burst_on     <= burst_on_next;
      if (pop) begin
        head  <= ptr_inc(head);
        count <= count - 1'b1;
      end
      if (push) begin
        tail  <= ptr_inc(tail);
        count <= count + 1'b1;
      end
    end
  end

endmodule

>>> rtl/acpi_ec_host_interface_top.sv
// channel | handshake             | payload
// --------+-----------------------+-------------------------
// in      | in_valid / in_ready   | mode, byte_in
// out     | out_valid / out_ready | byte_out, protocol_error
//
// One request per cycle while out is not stalled; out_valid is registered when the decode stage fires.
// The accepting edge registers the request and reads both memories; when it fires, the decode stage decodes,
// writes back (forwarded into a read issued at the same edge) and loads the output register.
// Reset is synchronous; the byte space reads as zero after reset via per-byte valid flags.
// A stall on out holds the decode stage and drops in_ready once both stages are occupied.
module acpi_ec_host_interface_top #(
  parameter int EVENT_DEPTH = ecif_pkg::DEF_EVENT_DEPTH,
  parameter int SPACE_BYTES = ecif_pkg::DEF_SPACE_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] mode,
  input  logic [7:0] byte_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] byte_out,
  output logic       protocol_error
);
  import ecif_pkg::*;

  logic       accept, fire;
  logic       b_valid;
  logic [2:0] b_mode;
  logic [7:0] b_byte;
  logic [7:0] sp_rdata, ev_rdata, ev_raddr;
  logic [7:0] res_byte;
  logic       res_err;
  wr_req_t    sp_wr, ev_wr;

  assign fire     = b_valid && (!out_valid || out_ready);
  assign in_ready = !b_valid || fire;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_ready) begin
      b_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_mode <= mode;
      b_byte <= byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      byte_out       <= res_byte;
      protocol_error <= res_err;
    end
  end

  ecif_space_mem #(
    .SPACE_BYTES(SPACE_BYTES)
  ) u_space (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_addr(byte_in),
    .wr     (sp_wr),
    .rd_data(sp_rdata)
  );

  ecif_event_mem #(
    .EVENT_DEPTH(EVENT_DEPTH)
  ) u_events (
    .clk    (clk),
    .rd_en  (accept),
    .rd_addr(ev_raddr),
    .wr     (ev_wr),
    .rd_data(ev_rdata)
  );

  ecif_ctrl #(
    .EVENT_DEPTH(EVENT_DEPTH),
    .SPACE_BYTES(SPACE_BYTES)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .b_mode  (b_mode),
    .b_byte  (b_byte),
    .sp_rdata(sp_rdata),
    .ev_rdata(ev_rdata),
    .sp_wr   (sp_wr),
    .ev_wr   (ev_wr),
    .ev_raddr(ev_raddr),
    .res_byte(res_byte),
    .res_err (res_err)
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ecif_pkg::*;

  localparam int EV_DEPTH    = DEF_EVENT_DEPTH;
  localparam int SPACE       = DEF_SPACE_BYTES;
  localparam int RAND_TARGET = 950;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_EVERY = 300;

  // modes the block must ignore
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0] m;
    logic [7:0] b;
    logic       known;
    logic [7:0] data;
    logic       err;
  } host_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       err;
  } ec_answer_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] mode = 3'd0;
  logic [7:0] byte_in = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] byte_out;
  logic       protocol_error;

  acpi_ec_host_interface_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .byte_in        (byte_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .byte_out       (byte_out),
    .protocol_error (protocol_error)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [7:0] ec_mem [SPACE];
  phase_t     ec_phase = PH_IDLE;
  logic [7:0] ec_off = 8'h00;
  logic [7:0] ec_obuf = 8'h00;
  logic       ec_ofull = 1'b0;
  logic       exp_burst = 1'b0;
  logic [7:0] ev_store [EV_DEPTH];
  int         ev_head = 0;
  int         ev_cnt = 0;

  ec_answer_t pending_answers [$];
  host_req_t  directed_rows [$];
  host_req_t  random_accesses [$];

  int cyc = 0;
  int mismatches = 0;
  int results_seen = 0;

  function automatic ec_answer_t ec_access(logic [2:0] m, logic [7:0] b);
    ec_answer_t r;
    r.data = 8'h00;
    r.err  = 1'b0;
    case (m)
      MODE_CMD: begin
        // any command restarts the sequence, a half-done one is dropped
        ec_phase = PH_IDLE;
        case (b)
          CMD_READ:      ec_phase = PH_RD_OFF;
          CMD_WRITE:     ec_phase = PH_WR_OFF;
          CMD_BURST_ON: begin
            exp_burst = 1'b1;
            ec_obuf   = BURST_REPLY;
            ec_ofull  = 1'b1;
          end
          CMD_BURST_OFF: exp_burst = 1'b0;
          CMD_QUERY: begin
            if (ev_cnt > 0) begin
              ec_obuf = ev_store[ev_head];
              ev_head = (ev_head + 1) % EV_DEPTH;
              ev_cnt--;
            end else begin
              ec_obuf = 8'h00;
            end
            ec_ofull = 1'b1;
          end
          default: r.err = 1'b1;
        endcase
      end
      MODE_DATA_W: begin
        case (ec_phase)
          PH_RD_OFF: begin
            ec_obuf  = (int'(b) < SPACE) ? ec_mem[b] : 8'h00;
            ec_ofull = 1'b1;
            ec_phase = PH_IDLE;
          end
          PH_WR_OFF: begin
            ec_off   = b;
            ec_phase = PH_WR_VAL;
          end
          PH_WR_VAL: begin
            if (int'(ec_off) < SPACE) ec_mem[ec_off] = b;
            ec_phase = PH_IDLE;
          end
          default: r.err = 1'b1;
        endcase
      end
      MODE_DATA_R: begin
        if (ec_ofull) begin
          r.data   = ec_obuf;
          ec_ofull = 1'b0;
        end else begin
          r.err = 1'b1;
        end
      end
      MODE_STATUS: begin
        r.data = (ec_ofull ? ST_OUT_FULL : 8'h00) | (exp_burst ? ST_BURST : 8'h00) |
                 ((ev_cnt > 0) ? ST_EVENT : 8'h00);
      end
      MODE_EVENT: begin
        if (ev_cnt >= EV_DEPTH) begin
          r.err = 1'b1;
        end else begin
          ev_store[(ev_head + ev_cnt) % EV_DEPTH] = b;
          ev_cnt++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic row(logic [2:0] m, logic [7:0] b, logic known, logic [7:0] d, logic e);
    host_req_t a;
    a.m = m; a.b = b; a.known = known; a.data = d; a.err = e;
    directed_rows.push_back(a);
  endtask

  task automatic acc(logic [2:0] m, logic [7:0] b);
    host_req_t a;
    a.m = m; a.b = b; a.known = 1'b0; a.data = 8'h00; a.err = 1'b0;
    random_accesses.push_back(a);
  endtask

  // mostly a small pool at both ends of the space so reads hit written bytes
  function automatic logic [7:0] pick_offset();
    if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, 255));
    return {($urandom_range(0, 1) != 0) ? 5'h1f : 5'h00, 3'($urandom_range(0, 7))};
  endfunction

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic plan_random(int target);
    int useful;
    int pick;
    int k;
    logic [2:0] m;
    useful = 0;
    while (useful < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        acc(MODE_CMD, CMD_WRITE); acc(MODE_DATA_W, pick_offset()); acc(MODE_DATA_W, rnd_byte());
        useful += 3;
      end else if (pick < 42) begin
        acc(MODE_CMD, CMD_READ); acc(MODE_DATA_W, pick_offset()); acc(MODE_DATA_R, rnd_byte());
        useful += 3;
        if ($urandom_range(0, 5) == 0) begin
          acc(MODE_DATA_R, rnd_byte());
          useful++;
        end
      end else if (pick < 50) begin
        acc(MODE_CMD, ($urandom_range(0, 1) != 0) ? CMD_BURST_ON : CMD_BURST_OFF);
        useful++;
        if ($urandom_range(0, 1) != 0) begin
          acc(MODE_DATA_R, rnd_byte());
          useful++;
        end
      end else if (pick < 60) begin
        acc(MODE_CMD, CMD_QUERY);
        useful++;
        if ($urandom_range(0, 2) != 0) begin
          acc(MODE_DATA_R, rnd_byte());
          useful++;
        end
      end else if (pick < 70) begin
        k = $urandom_range(1, 3);
        repeat (k) acc(MODE_EVENT, rnd_byte());
        useful += k;
      end else if (pick < 73) begin
        // enough raises to overflow the event queue
        k = $urandom_range(EV_DEPTH + 1, EV_DEPTH + 3);
        repeat (k) acc(MODE_EVENT, rnd_byte());
        useful += k;
      end else if (pick < 80) begin
        acc(MODE_STATUS, rnd_byte());
        useful++;
      end else if (pick < 90) begin
        m = 3'($urandom_range(0, 7));
        acc(m, rnd_byte());
        if (m <= MODE_EVENT) useful++;
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            acc(MODE_CMD, CMD_WRITE); acc(MODE_DATA_W, pick_offset());
            acc(MODE_CMD, ($urandom_range(0, 1) != 0) ? CMD_QUERY : rnd_byte());
            useful += 3;
          end
          1: begin
            // status read in the middle must not disturb the sequence
            acc(MODE_CMD, CMD_READ); acc(MODE_STATUS, rnd_byte());
            acc(MODE_DATA_W, pick_offset());
            useful += 3;
          end
          default: begin
            acc(MODE_DATA_W, rnd_byte());
            useful++;
          end
        endcase
      end
    end
  endtask

  task automatic send_access(host_req_t a);
    ec_answer_t want;
    in_valid <= 1'b1;
    mode     <= a.m;
    byte_in  <= a.b;
    do @(posedge clk); while (in_ready !== 1'b1);
    want = ec_access(a.m, a.b);
    if (a.known) begin
      want.data = a.data;
      want.err  = a.err;
    end
    pending_answers.push_back(want);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    if (mismatches < 100)
      $display("mismatch cycle %0d: %s got %02h expected %02h", cyc, what, got, want);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin
    ec_answer_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      results_seen++;
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result byte_out", byte_out, 8'h00);
      end else begin
        want = pending_answers.pop_front();
        if (byte_out !== want.data) report_mismatch("byte_out", byte_out, want.data);
        if (protocol_error !== want.err)
          report_mismatch("protocol_error", {7'd0, protocol_error}, {7'd0, want.err});
      end
    end
  end

  // receiver: changing stall styles, rare random hold-offs and one long one
  int  rx_hold = 0;
  int  rx_tick = 0;
  int  rx_style = 0;
  bit  long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold   <= rx_hold - 1;
      end else if (!long_hold_done && results_seen >= 150) begin
        out_ready      <= 1'b0;
        rx_hold        <= 80;
        long_hold_done <= 1'b1;
      end else if ($urandom_range(0, 499) == 0) begin
        out_ready <= 1'b0;
        rx_hold   <= $urandom_range(20, 60);
      end else begin
        case (rx_style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 9) != 0);
          default: out_ready <= ((rx_tick % 3) == 0);
        endcase
      end
      rx_tick <= rx_tick + 1;
      if ((rx_tick % 128) == 127) rx_style <= $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int burst_left;
    int gap;
    int sent;
    host_req_t a;

    foreach (ec_mem[i]) ec_mem[i] = 8'h00;
    foreach (ev_store[i]) ev_store[i] = 8'h00;

    // after reset, error cases, ignored modes
    row(MODE_STATUS, 8'h00, 1'b1, 8'h00, 1'b0);
    row(MODE_DATA_R, 8'hff, 1'b1, 8'h00, 1'b1);
    row(MODE_DATA_W, 8'hff, 1'b1, 8'h00, 1'b1);
    row(MODE_CMD, 8'h00, 1'b1, 8'h00, 1'b1);
    row(MODE_CMD, 8'hff, 1'b1, 8'h00, 1'b1);
    row(MODE_SPARE_HI, 8'hff, 1'b1, 8'h00, 1'b0);
    row(MODE_SPARE_LO, 8'h00, 1'b1, 8'h00, 1'b0);
    // write then read back the top byte
    row(MODE_CMD, CMD_WRITE, 1'b0, 8'h00, 1'b0);
    row(MODE_DATA_W, 8'hff, 1'b0, 8'h00, 1'b0);
    row(MODE_DATA_W, 8'ha5, 1'b0, 8'h00, 1'b0);
    row(MODE_CMD, CMD_READ, 1'b0, 8'h00, 1'b0);
    row(MODE_DATA_W, 8'hff, 1'b0, 8'h00, 1'b0);
    row(MODE_DATA_R, 8'h00, 1'b0, 8'h00, 1'b0);
    // byte space cleared at reset
    row(MODE_CMD, CMD_READ, 1'b0, 8'h00, 1'b0);
    row(MODE_DATA_W, 8'h00, 1'b0, 8'h00, 1'b0);
    row(MODE_DATA_R, 8'h00, 1'b1, 8'h00, 1'b0);
    // burst, twice so the unread answer is overwritten
    row(MODE_CMD, CMD_BURST_ON, 1'b0, 8'h00, 1'b0);
    row(MODE_CMD, CMD_BURST_ON, 1'b0, 8'h00, 1'b0);
    row(MODE_STATUS, 8'h00, 1'b1, ST_OUT_FULL | ST_BURST, 1'b0);
    row(MODE_DATA_R, 8'h00, 1'b1, BURST_REPLY, 1'b0);
    row(MODE_CMD, CMD_BURST_OFF, 1'b0, 8'h00, 1'b0);
    // query with nothing pending
    row(MODE_CMD, CMD_QUERY, 1'b0, 8'h00, 1'b0);
    row(MODE_DATA_R, 8'h00, 1'b1, 8'h00, 1'b0);
    // event zero; a write command cut short by a query
    row(MODE_EVENT, 8'h00, 1'b0, 8'h00, 1'b0);
    row(MODE_STATUS, 8'h00, 1'b1, ST_EVENT, 1'b0);
    row(MODE_CMD, CMD_WRITE, 1'b0, 8'h00, 1'b0);
    row(MODE_CMD, CMD_QUERY, 1'b0, 8'h00, 1'b0);
    row(MODE_DATA_R, 8'h00, 1'b1, 8'h00, 1'b0);

    plan_random(RAND_TARGET);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      send_access(directed_rows[k]);
      if ($urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
    drain();

    burst_left = 0;
    sent = 0;
    while (random_accesses.size() > 0) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 :
              ($urandom_range(0, 7) == 0) ? $urandom_range(6, 15) : $urandom_range(1, 5);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100) :
                     $urandom_range(1, 12);
      end
      a = random_accesses.pop_front();
      send_access(a);
      burst_left--;
      sent++;
      if ((sent % DRAIN_EVERY) == 0) begin
        drain();
        burst_left = 0;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
